// File: src/helicity_pdf_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the helicity distribution evaluator
// Concurrent checks clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef HELICITY_PDF_EVALUATOR_MACROS_SVH
`define HELICITY_PDF_EVALUATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define HPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HPE_ASSERT(lbl, prop, msg)
`define HPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Widths, register codes, stage records and arithmetic helpers shared by the
// evaluator and its channel interfaces.
// ----------------------------------------------------------------------------
package hpe_pkg;

  localparam int X_W     = 16;
  localparam int COEF_W  = 16;
  localparam int ALPHA_W = 13;
  localparam int OUT_W   = 48;
  localparam int IDX_W   = 3;
  localparam int NLOG    = 16;
  localparam int NEXP    = 16;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic [IDX_W-1:0] REG_ALPHA      = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_A     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_B     = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_C     = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_C_LOG = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_D     = 3'd5;

  localparam logic [ALPHA_W-1:0] ALPHA_RST      = 13'd4096;
  localparam logic [COEF_W-1:0]  COEF_A_RST     = 16'd4096;
  localparam logic [COEF_W-1:0]  COEF_B_RST     = 16'd4096;
  localparam logic [COEF_W-1:0]  COEF_C_RST     = 16'd8778;
  localparam logic [COEF_W-1:0]  COEF_C_LOG_RST = 16'd2019;
  localparam logic [COEF_W-1:0]  COEF_D_RST     = 16'd4096;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [30:0] m;
    logic [15:0] f;
    logic [3:0]  p;
  } lg_t;

  typedef struct packed {
    logic             rng;
    logic             mode;
    logic [15:0]      y;
    logic [6:2][15:0] yp;
    lg_t              lx;
    lg_t              ly;
  } lstage_t;

  typedef struct packed {
    logic             rng;
    logic             mode;
    logic [4:0]       k;
    logic [15:0]      g;
    logic [19:0]      ln;
    logic [6:3][15:0] yp;
  } astage_t;

  typedef struct packed {
    logic             rng;
    logic             mode;
    logic [4:0]       k;
    logic [15:0]      g;
    logic [31:0]      mant;
    logic [6:3][15:0] yp;
    logic [23:0]      sq;
    logic [23:0]      t;
    logic [40:0]      sum;
    logic [28:0]      poly;
  } estage_t;

  typedef struct packed {
    logic        rng;
    logic [4:0]  k;
    logic [60:0] prod;
  } mstage_t;

  function automatic logic [3:0] lead_one(input logic [15:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction

  function automatic lg_t log_seed(input logic [15:0] v);
    lg_t l;
    l.p = lead_one(v);
    l.m = 31'(v) << (5'd30 - 5'(l.p));
    l.f = '0;
    return l;
  endfunction

  // square the mantissa and take one fraction bit
  function automatic lg_t log_step(input lg_t l);
    logic [61:0] sq;
    logic [31:0] r;
    lg_t         n;
    sq  = 62'(l.m) * 62'(l.m);
    r   = sq[61:30];
    n.p = l.p;
    n.f = {l.f[14:0], r[31]};
    n.m = r[31] ? r[31:1] : r[30:0];
    return n;
  endfunction

  function automatic logic [20:0] log_done(input lg_t l);
    return {5'd16 - 5'(l.p), 16'd0} - {5'd0, l.f};
  endfunction

  function automatic logic [15:0] ypow(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] pr;
    pr = 32'(a) * 32'(b);
    return pr[31:16];
  endfunction

  function automatic logic [31:0] exp_mul(input logic [31:0] a, input logic [31:0] c);
    logic [63:0] pr;
    pr = 64'(a) * 64'(c);
    return pr[61:30];
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] rem;
    res = '0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-n) in Q1.30 by repeated square roots of 2.0
  function automatic logic [31:0] exp2_factor(input int n);
    logic [63:0] c;
    c = 64'd1 << 31;
    for (int j = 1; j <= n; j++) begin
      c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

// File: src/hpe_sample_if.sv
// ----------------------------------------------------------------------------
// hpe_sample_if
// Input channel: one momentum fraction and form select per item.
// ----------------------------------------------------------------------------
interface hpe_sample_if;
  import hpe_pkg::*;
  logic           valid;
  logic           ready;
  logic [X_W-1:0] x_frac;
  logic           mode;
  modport source (output valid, x_frac, mode, input ready);
  modport sink   (input valid, x_frac, mode, output ready);
endinterface

// File: src/hpe_result_if.sv
// ----------------------------------------------------------------------------
// hpe_result_if
// Output channel: distribution value with range and saturation flags.
// ----------------------------------------------------------------------------
interface hpe_result_if;
  import hpe_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pdf_value;
  logic             in_range;
  logic             saturated;
  modport source (output valid, pdf_value, in_range, saturated, input ready);
  modport sink   (input valid, pdf_value, in_range, saturated, output ready);
endinterface

// File: src/hpe_cfg_if.sv
// ----------------------------------------------------------------------------
// hpe_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hpe_cfg_if;
  import hpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [COEF_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/helicity_pdf_evaluator.sv
// Throughput: one item per cycle; the pipeline is one 31x31 squaring or
// Q1.30 product deep per stage (16 log stages, 16 exp stages, 5 others).
// A stall at the output holds every stage in place.
// Reset (rst, synchronous) clears all valid bits and reloads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// helicity_pdf_evaluator
// Evaluates x^-alpha times the positive or negative helicity polynomial in
// y = 1 - x, using pipelined base-2 log and exp in fixed point.
// ----------------------------------------------------------------------------
`include "helicity_pdf_evaluator_macros.svh"

module helicity_pdf_evaluator (
  input logic          clk,
  input logic          rst,
  hpe_sample_if.sink   sample,
  hpe_result_if.source result,
  hpe_cfg_if.sink      cfg
);
  import hpe_pkg::*;

  logic [ALPHA_W-1:0] alpha_exp;
  logic [COEF_W-1:0]  coef_a;
  logic [COEF_W-1:0]  coef_b;
  logic [COEF_W-1:0]  coef_c;
  logic [COEF_W-1:0]  coef_c_log;
  logic [COEF_W-1:0]  coef_d;

  logic    en;
  lstage_t lp [0:NLOG];
  logic    lv [0:NLOG];
  astage_t ap;
  logic    av;
  estage_t ep [0:NEXP];
  logic    ev [0:NEXP];
  mstage_t mp;
  logic    mv;
  logic    ov;

  assign en           = !ov || result.ready;
  assign sample.ready = en && !rst;
  assign cfg.ready    = !rst;
  assign result.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_exp  <= ALPHA_RST;
      coef_a     <= COEF_A_RST;
      coef_b     <= COEF_B_RST;
      coef_c     <= COEF_C_RST;
      coef_c_log <= COEF_C_LOG_RST;
      coef_d     <= COEF_D_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ALPHA:      alpha_exp  <= cfg.data[ALPHA_W-1:0];
        REG_COEF_A:     coef_a     <= cfg.data;
        REG_COEF_B:     coef_b     <= cfg.data;
        REG_COEF_C:     coef_c     <= cfg.data;
        REG_COEF_C_LOG: coef_c_log <= cfg.data;
        REG_COEF_D:     coef_d     <= cfg.data;
        default: ;
      endcase
    end
  end

  // entry stage: form y and normalise both log mantissas
  lstage_t l0_next;
  always_comb begin
    l0_next      = '0;
    l0_next.rng  = sample.x_frac != '0;
    l0_next.mode = sample.mode;
    l0_next.y    = 16'(17'd65536 - {1'b0, sample.x_frac});
    l0_next.lx   = log_seed(sample.x_frac);
    l0_next.ly   = log_seed(l0_next.y);
  end

  always_ff @(posedge clk) begin
    if (rst) lv[0] <= 1'b0;
    else if (en) lv[0] <= sample.valid;
  end
  always_ff @(posedge clk) begin
    if (en) lp[0] <= l0_next;
  end

  // log stages: one squaring per lane, y powers alongside
  for (genvar i = 1; i <= NLOG; i++) begin : g_log
    lstage_t step;
    lstage_t nx;
    always_comb begin
      step    = lp[i-1];
      step.lx = log_step(lp[i-1].lx);
      step.ly = log_step(lp[i-1].ly);
    end
    if (i == 1) begin : g_y2
      always_comb begin
        nx       = step;
        nx.yp[2] = ypow(lp[i-1].y, lp[i-1].y);
      end
    end else if (i <= 5) begin : g_yn
      always_comb begin
        nx         = step;
        nx.yp[i+1] = ypow(lp[i-1].yp[i], lp[i-1].y);
      end
    end else begin : g_carry
      always_comb nx = step;
    end
    always_ff @(posedge clk) begin
      if (rst) lv[i] <= 1'b0;
      else if (en) lv[i] <= lv[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) lp[i] <= nx;
    end
  end

  // scale log2(1/x) by alpha, convert log2(1/y) to ln
  logic [20:0] nlx;
  logic [20:0] nly;
  logic [33:0] ea;
  logic [36:0] lnp;
  astage_t     a_next;
  always_comb begin
    nlx         = log_done(lp[NLOG].lx);
    nly         = log_done(lp[NLOG].ly);
    ea          = 34'(alpha_exp) * 34'(nlx);
    lnp         = 37'(nly) * 37'(LN2_Q16);
    a_next.rng  = lp[NLOG].rng;
    a_next.mode = lp[NLOG].mode;
    a_next.k    = ea[32:28];
    a_next.g    = ea[27:12];
    a_next.ln   = lnp[35:16];
    a_next.yp   = lp[NLOG].yp[6:3];
  end

  always_ff @(posedge clk) begin
    if (rst) av <= 1'b0;
    else if (en) av <= lv[NLOG];
  end
  always_ff @(posedge clk) begin
    if (en) ap <= a_next;
  end

  logic [39:0] sqp;
  estage_t     e0_next;
  always_comb begin
    sqp          = 40'(ap.ln) * 40'(ap.ln);
    e0_next      = '0;
    e0_next.rng  = ap.rng;
    e0_next.mode = ap.mode;
    e0_next.k    = ap.k;
    e0_next.g    = ap.g;
    e0_next.mant = ONE_Q30;
    e0_next.yp   = ap.yp;
    e0_next.sq   = sqp[39:16];
  end

  always_ff @(posedge clk) begin
    if (rst) ev[0] <= 1'b0;
    else if (en) ev[0] <= av;
  end
  always_ff @(posedge clk) begin
    if (en) ep[0] <= e0_next;
  end

  // exp stages: one factor 2^(2^-i) per stage, polynomial in the first three
  for (genvar i = 1; i <= NEXP; i++) begin : g_exp
    localparam logic [31:0] FACTOR = exp2_factor(i);
    estage_t step;
    estage_t nx;
    always_comb begin
      step = ep[i-1];
      if (ep[i-1].g[NEXP-i]) step.mant = exp_mul(ep[i-1].mant, FACTOR);
    end
    if (i == 1) begin : g_t
      logic [39:0] tp;
      always_comb begin
        tp   = 40'(ep[i-1].yp[5]) * 40'(ep[i-1].sq);
        nx   = step;
        nx.t = tp[39:16];
      end
    end else if (i == 2) begin : g_sum
      always_comb begin
        nx = step;
        if (ep[i-1].mode) begin
          nx.sum = 41'(coef_c) * 41'(ep[i-1].yp[5])
                 + 41'(coef_c_log) * 41'(ep[i-1].t)
                 + 41'(coef_d) * 41'(ep[i-1].yp[6]);
        end else begin
          nx.sum = 41'(coef_a) * 41'(ep[i-1].yp[3])
                 + 41'(coef_b) * 41'(ep[i-1].yp[4]);
        end
      end
    end else if (i == 3) begin : g_poly
      always_comb begin
        nx      = step;
        nx.poly = ep[i-1].sum[40:12];
      end
    end else begin : g_carry
      always_comb nx = step;
    end
    always_ff @(posedge clk) begin
      if (rst) ev[i] <= 1'b0;
      else if (en) ev[i] <= ev[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) ep[i] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mv <= 1'b0;
    else if (en) mv <= ev[NEXP];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mp.rng  <= ep[NEXP].rng;
      mp.k    <= ep[NEXP].k;
      mp.prod <= 61'(ep[NEXP].mant) * 61'(ep[NEXP].poly);
    end
  end

  // scale by 2^(k-30) and saturate
  logic [91:0] wide;
  logic [61:0] val;
  logic        sat;
  always_comb begin
    wide = 92'(mp.prod) << mp.k;
    val  = wide[91:30];
    sat  = |val[61:48];
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= mv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!mp.rng) begin
        result.pdf_value <= '0;
        result.in_range  <= 1'b0;
        result.saturated <= 1'b0;
      end else begin
        result.pdf_value <= sat ? {OUT_W{1'b1}} : val[OUT_W-1:0];
        result.in_range  <= 1'b1;
        result.saturated <= sat;
      end
    end
  end

  `HPE_ASSERT(a_out_of_range_zero, !(ov && !result.in_range) || (result.pdf_value == '0 && !result.saturated), "out of range item gave a non-zero result")
  `HPE_ASSERT(a_sat_full_scale, !(ov && result.saturated) || (result.pdf_value == {OUT_W{1'b1}}), "saturated result not at full scale")
  `HPE_ASSERT_NEXT(a_zero_product, en && mv && mp.prod == '0, result.pdf_value == '0 && !result.saturated, "zero product gave a non-zero result")
  `HPE_ASSERT_NEXT(a_hold_on_stall, !en, ov && $stable(result.pdf_value), "result changed during a stall")

endmodule
